// File: sv/yuvc_pkg.sv
`timescale 1ns / 1ps

package yuvc_pkg;

    // Mode register codes
    localparam logic [1:0] MODE_PLAIN     = 2'd0;
    localparam logic [1:0] MODE_KEY_WIPE  = 2'd1;
    localparam logic [1:0] MODE_CROSSFADE = 2'd2;
    localparam logic [1:0] MODE_SIDE      = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_MODE        = 2'd0;
    localparam logic [1:0] CFG_FADE_WEIGHT = 2'd1;
    localparam logic [1:0] CFG_WIPE_COLUMN = 2'd2;

    localparam int unsigned CFG_DATA_W = 10;

    // Crossfade weight scale and the largest legal weight
    localparam logic [8:0] WEIGHT_FULL = 9'd300;
    localparam logic [8:0] WEIGHT_MAX  = 9'd299;

    // floor(2^18 / 300); the quotient it gives is low by at most one
    localparam logic [9:0] RECIP_300   = 10'd873;
    localparam int unsigned RECIP_SHIFT = 18;

    localparam logic [7:0] WIPE_RED   = 8'd100;
    localparam logic [7:0] WIPE_GREEN = 8'd150;
    localparam logic [7:0] WIPE_BLUE  = 8'd200;

    typedef struct packed {
        logic [7:0] luma_a;
        logic [7:0] cb_a;
        logic [7:0] cr_a;
        logic [7:0] luma_b;
        logic [7:0] cb_b;
        logic [7:0] cr_b;
        logic [7:0] back_red;
        logic [7:0] back_green;
        logic [7:0] back_blue;
        logic [9:0] column;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] second_red;
        logic [7:0] second_green;
        logic [7:0] second_blue;
    } t_pix_out;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // Pipeline control shared by the stage modules
    typedef struct packed {
        logic en;
    } t_pipe_ctl;

    // floor(s / 256) clamped to 0..255
    function automatic logic [7:0] scale_clamp(input logic signed [18:0] s);
        logic [7:0] res;
        if (s[18]) begin
            res = 8'd0;
        end else if (s[17:16] != 2'b00) begin
            res = 8'd255;
        end else begin
            res = s[15:8];
        end
        return res;
    endfunction

endpackage

// File: sv/yuvc_if.sv
`timescale 1ns / 1ps

interface yuvc_pix_if;
    import yuvc_pkg::*;
    logic    valid;
    logic    ready;
    t_pix_in data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface yuvc_rgb_if;
    import yuvc_pkg::*;
    logic     valid;
    logic     ready;
    t_pix_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface yuvc_cfg_if;
    import yuvc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [1:0]            index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/yuvc_csc.sv
`timescale 1ns / 1ps

module yuvc_csc (
    input  logic                 i_clk,
    input  yuvc_pkg::t_pipe_ctl  i_ctl,
    input  logic [7:0]           i_luma,
    input  logic [7:0]           i_cb,
    input  logic [7:0]           i_cr,
    output yuvc_pkg::t_rgb       o_rgb
);
    import yuvc_pkg::*;

    logic signed [9:0]  c_off;
    logic signed [9:0]  d_off;
    logic signed [9:0]  e_off;
    logic signed [17:0] n_ty, n_tr, n_tg, n_tb;
    logic signed [17:0] r_ty, r_tr, r_tg, r_tb;
    logic signed [18:0] sum_r, sum_g, sum_b;
    t_rgb               n_rgb;
    t_rgb               r_rgb;

    assign c_off = signed'({2'b00, i_luma}) - 10'sd16;
    assign d_off = signed'({2'b00, i_cb}) - 10'sd128;
    assign e_off = signed'({2'b00, i_cr}) - 10'sd128;

    // Stage 1: constant products
    always_comb begin
        n_ty = 18'(18'(c_off) * 18'sd298 + 18'sd128);
        n_tr = 18'(18'(e_off) * 18'sd409);
        n_tg = 18'(18'sd0 - 18'(d_off) * 18'sd100 - 18'(e_off) * 18'sd208);
        n_tb = 18'(18'(d_off) * 18'sd516);
    end

    // Stage 2: sums, scale and clamp; blue can pass 2^17, so widen by one
    always_comb begin
        sum_r = 19'(r_ty) + 19'(r_tr);
        sum_g = 19'(r_ty) + 19'(r_tg);
        sum_b = 19'(r_ty) + 19'(r_tb);
        n_rgb.red   = scale_clamp(sum_r);
        n_rgb.green = scale_clamp(sum_g);
        n_rgb.blue  = scale_clamp(sum_b);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_ty  <= n_ty;
            r_tr  <= n_tr;
            r_tg  <= n_tg;
            r_tb  <= n_tb;
            r_rgb <= n_rgb;
        end
    end

    assign o_rgb = r_rgb;

endmodule

// File: sv/yuvc_blend.sv
`timescale 1ns / 1ps

module yuvc_blend (
    input  logic                 i_clk,
    input  yuvc_pkg::t_pipe_ctl  i_ctl,
    input  yuvc_pkg::t_rgb       i_a,
    input  yuvc_pkg::t_rgb       i_b,
    input  logic [8:0]           i_weight,
    output yuvc_pkg::t_rgb       o_mix
);
    import yuvc_pkg::*;

    logic [2:0][7:0]  a_comp;
    logic [2:0][7:0]  b_comp;
    logic [8:0]       w_inv;
    logic [2:0][16:0] n_x;
    logic [2:0][16:0] r_x;
    logic [2:0][16:0] r_x_d;
    logic [2:0][26:0] prod;
    logic [2:0][7:0]  n_q0;
    logic [2:0][7:0]  r_q0;
    logic [2:0][16:0] rem;
    logic [2:0][7:0]  n_q;
    logic [2:0][7:0]  r_q;

    assign a_comp = {i_a.red, i_a.green, i_a.blue};
    assign b_comp = {i_b.red, i_b.green, i_b.blue};
    assign w_inv  = WEIGHT_FULL - i_weight;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            // Stage 3: weighted sum
            n_x[k] = 17'(17'(a_comp[k]) * 17'(w_inv)) + 17'(17'(b_comp[k]) * 17'(i_weight));
            // Stage 4: reciprocal estimate of x / 300
            prod[k] = 27'(r_x[k]) * 27'(RECIP_300);
            n_q0[k] = prod[k][RECIP_SHIFT +: 8];
            // Stage 5: fix the estimate up by one where the remainder overflows
            rem[k]  = r_x_d[k] - 17'(17'(r_q0[k]) * 17'd300);
            n_q[k]  = (rem[k] >= 17'(WEIGHT_FULL)) ? r_q0[k] + 8'd1 : r_q0[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_x   <= n_x;
            r_x_d <= r_x;
            r_q0  <= n_q0;
            r_q   <= n_q;
        end
    end

    assign o_mix.red   = r_q[2];
    assign o_mix.green = r_q[1];
    assign o_mix.blue  = r_q[0];

endmodule

// File: sv/yuv_to_rgb_compositor_unit.sv
`timescale 1ns / 1ps

// YUV to RGB compositor.
// i_pix carries one pixel of sources A and B (Y, U, V each), a background
// RGB pixel and its column; o_rgb returns one composited pixel per input
// transfer, with source B in RGB on the second_* fields. i_cfg writes the
// mode (index 0), the crossfade weight (1) and the wipe column (2); writes
// are taken in any cycle, but change them only while the pipeline is empty.
// From input transfer to o_rgb the pipeline has six register stages: two
// for the color conversion, three for the crossfade multiply and divide
// by 300, one for the mode select.
// Throughput is one pixel per clock while o_rgb.ready stays high.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and i_pix.ready drops; nothing is lost or repeated. Bubbles move forward
// while the output register is empty.
// Synchronous active-low reset empties the pipeline and sets all three
// registers to zero (plain mode).
module yuv_to_rgb_compositor_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    yuvc_pix_if.sink     i_pix,
    yuvc_cfg_if.sink     i_cfg,
    yuvc_rgb_if.source   o_rgb
);
    import yuvc_pkg::*;

    localparam int unsigned NSTAGE = 6;
    localparam int unsigned NSIDE  = 5;
    localparam int unsigned NDLY   = 3;

    typedef struct packed {
        t_rgb back;
        logic black;
        logic wipe;
    } t_side;

    logic [1:0]              r_mode;
    logic [8:0]              r_fade_weight;
    logic [9:0]              r_wipe_column;
    logic [8:0]              weight_sat;
    logic [NSTAGE-1:0]       r_vld;
    t_pipe_ctl               ctl;
    t_side                   side_in;
    t_side [NSIDE-1:0]       r_side;
    t_rgb                    conv_a;
    t_rgb                    conv_b;
    t_rgb                    mix;
    t_rgb [NDLY-1:0]         r_a_dly;
    t_rgb [NDLY-1:0]         r_b_dly;
    t_side                   side_end;
    t_rgb                    a_end;
    t_rgb                    main_rgb;
    t_pix_out                n_out;
    t_pix_out                r_out;

    // Configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_PLAIN;
            r_fade_weight <= '0;
            r_wipe_column <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_MODE:        r_mode        <= i_cfg.data[1:0];
                CFG_FADE_WEIGHT: r_fade_weight <= i_cfg.data[8:0];
                CFG_WIPE_COLUMN: r_wipe_column <= i_cfg.data[9:0];
                default:         ;
            endcase
        end
    end

    assign weight_sat = (r_fade_weight > WEIGHT_MAX) ? WEIGHT_MAX : r_fade_weight;

    // Advance everything unless a result is held at the output
    assign ctl.en      = !r_vld[NSTAGE-1] || o_rgb.ready;
    assign i_pix.ready = ctl.en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ctl.en) begin
            r_vld <= {r_vld[NSTAGE-2:0], i_pix.valid};
        end
    end

    // Key decision is made at entry and travels with the pixel
    assign side_in.back  = '{red:   i_pix.data.back_red,
                             green: i_pix.data.back_green,
                             blue:  i_pix.data.back_blue};
    assign side_in.black = (i_pix.data.back_red == 8'd0) &&
                           (i_pix.data.back_green == 8'd0) &&
                           (i_pix.data.back_blue == 8'd0);
    assign side_in.wipe  = i_pix.data.column < r_wipe_column;

    yuvc_csc u_csc_a (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_luma (i_pix.data.luma_a),
        .i_cb   (i_pix.data.cb_a),
        .i_cr   (i_pix.data.cr_a),
        .o_rgb  (conv_a)
    );

    yuvc_csc u_csc_b (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_luma (i_pix.data.luma_b),
        .i_cb   (i_pix.data.cb_b),
        .i_cr   (i_pix.data.cr_b),
        .o_rgb  (conv_b)
    );

    yuvc_blend u_blend (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_a      (conv_a),
        .i_b      (conv_b),
        .i_weight (weight_sat),
        .o_mix    (mix)
    );

    always_ff @(posedge i_clk) begin
        if (ctl.en) begin
            r_side  <= {r_side[NSIDE-2:0], side_in};
            r_a_dly <= {r_a_dly[NDLY-2:0], conv_a};
            r_b_dly <= {r_b_dly[NDLY-2:0], conv_b};
            r_out   <= n_out;
        end
    end

    assign side_end = r_side[NSIDE-1];
    assign a_end    = r_a_dly[NDLY-1];

    always_comb begin
        case (r_mode)
            MODE_KEY_WIPE: begin
                if (side_end.black) begin
                    main_rgb = a_end;
                end else if (side_end.wipe) begin
                    main_rgb = '{red: WIPE_RED, green: WIPE_GREEN, blue: WIPE_BLUE};
                end else begin
                    main_rgb = side_end.back;
                end
            end
            MODE_CROSSFADE: main_rgb = mix;
            default:        main_rgb = a_end;
        endcase
        n_out.out_red      = main_rgb.red;
        n_out.out_green    = main_rgb.green;
        n_out.out_blue     = main_rgb.blue;
        n_out.second_red   = r_b_dly[NDLY-1].red;
        n_out.second_green = r_b_dly[NDLY-1].green;
        n_out.second_blue  = r_b_dly[NDLY-1].blue;
    end

    assign o_rgb.valid = r_vld[NSTAGE-1];
    assign o_rgb.data  = r_out;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import yuvc_pkg::*;

    // Index with no register behind it; a write there must change nothing
    localparam logic [1:0] CFG_SPARE = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #10 clk = ~clk;

    yuvc_pix_if pix ();
    yuvc_cfg_if cfg ();
    yuvc_rgb_if rgb ();

    logic                  pix_valid = 1'b0;
    t_pix_in               pix_data = '0;
    logic                  cfg_valid = 1'b0;
    logic [1:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  rgb_ready = 1'b0;

    assign pix.valid = pix_valid;
    assign pix.data  = pix_data;
    assign cfg.valid = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;
    assign rgb.ready = rgb_ready;

    yuv_to_rgb_compositor_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pix   (pix),
        .i_cfg   (cfg),
        .o_rgb   (rgb)
    );

    // Shadow copy of the block's registers
    logic [1:0] reg_mode = MODE_PLAIN;
    logic [8:0] reg_weight = '0;
    logic [9:0] reg_wipe = '0;

    t_pix_in     pixel_backlog[$];
    t_pix_out    predicted_rgb[$];
    int unsigned mismatch_count = 0;

    int unsigned src_idle = 0;
    int unsigned snk_idle = 0;
    int unsigned src_wait = 0;
    int unsigned snk_wait = 0;
    logic        hold_go = 1'b0;
    logic        out_hold = 1'b0;
    t_pix_out    want;

    // floor(x / 256), saturated to a byte
    function automatic logic [7:0] sat_byte(input int x);
        int q;
        q = x >>> 8;
        if (q < 0) return 8'd0;
        if (q > 255) return 8'd255;
        return 8'(q);
    endfunction

    function automatic t_rgb yuv_to_rgb(input logic [7:0] y, input logic [7:0] u,
                                        input logic [7:0] v);
        int   c;
        int   d;
        int   e;
        t_rgb px;
        c = int'(y) - 16;
        d = int'(u) - 128;
        e = int'(v) - 128;
        px.red   = sat_byte(298 * c + 409 * e + 128);
        px.green = sat_byte(298 * c - 100 * d - 208 * e + 128);
        px.blue  = sat_byte(298 * c + 516 * d + 128);
        return px;
    endfunction

    function automatic logic [7:0] fade_mix(input logic [7:0] a, input logic [7:0] b,
                                            input int w);
        return 8'((int'(a) * (int'(WEIGHT_FULL) - w) + int'(b) * w) / int'(WEIGHT_FULL));
    endfunction

    function automatic t_pix_out composite_pixel(input t_pix_in p);
        t_rgb     a;
        t_rgb     b;
        t_rgb     m;
        int       w;
        t_pix_out res;
        a = yuv_to_rgb(p.luma_a, p.cb_a, p.cr_a);
        b = yuv_to_rgb(p.luma_b, p.cb_b, p.cr_b);
        case (reg_mode)
            MODE_KEY_WIPE: begin
                if (p.back_red == 0 && p.back_green == 0 && p.back_blue == 0) begin
                    m = a;
                end else if (p.column < reg_wipe) begin
                    m = '{WIPE_RED, WIPE_GREEN, WIPE_BLUE};
                end else begin
                    m = '{p.back_red, p.back_green, p.back_blue};
                end
            end
            MODE_CROSSFADE: begin
                // saturate out-of-range weights
                w = (reg_weight > WEIGHT_MAX) ? int'(WEIGHT_MAX) : int'(reg_weight);
                m.red   = fade_mix(a.red, b.red, w);
                m.green = fade_mix(a.green, b.green, w);
                m.blue  = fade_mix(a.blue, b.blue, w);
            end
            default: begin
                m = a;
            end
        endcase
        res.out_red      = m.red;
        res.out_green    = m.green;
        res.out_blue     = m.blue;
        res.second_red   = b.red;
        res.second_green = b.green;
        res.second_blue  = b.blue;
        return res;
    endfunction

    function automatic int unsigned draw_gap(input int unsigned level);
        if (level == 0) return 0;
        if (level == 1) return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
        return $urandom_range(0, 19);
    endfunction

    function automatic void check_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    function automatic t_pix_in mk_pixel(
        input logic [7:0] ya, input logic [7:0] ua, input logic [7:0] va,
        input logic [7:0] yb, input logic [7:0] ub, input logic [7:0] vb,
        input logic [7:0] r, input logic [7:0] g, input logic [7:0] bl,
        input logic [9:0] col);
        return {ya, ua, va, yb, ub, vb, r, g, bl, col};
    endfunction

    // Mostly uniform, with the range ends and the nominal levels now and then
    function automatic logic [7:0] rand_sample();
        if ($urandom_range(0, 7) != 0) return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 4))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd16;
            3: return 8'd235;
            default: return 8'd128;
        endcase
    endfunction

    function automatic t_pix_in random_pixel();
        t_pix_in p;
        int      c;
        p.luma_a = rand_sample();
        p.cb_a   = rand_sample();
        p.cr_a   = rand_sample();
        p.luma_b = rand_sample();
        p.cb_b   = rand_sample();
        p.cr_b   = rand_sample();
        if ($urandom_range(0, 2) == 0) begin
            p.back_red   = 8'd0;
            p.back_green = 8'd0;
            p.back_blue  = 8'd0;
        end else begin
            p.back_red   = rand_sample();
            p.back_green = rand_sample();
            p.back_blue  = rand_sample();
        end
        // hug the wipe edge a quarter of the time
        if ($urandom_range(0, 3) == 0) begin
            c = int'(reg_wipe) + int'($urandom_range(0, 3)) - 2;
            if (c < 0) c = 0;
            if (c > 1023) c = 1023;
            p.column = 10'(c);
        end else begin
            p.column = 10'($urandom_range(0, 1023));
        end
        return p;
    endfunction

    // Sender: hold an offered pixel until it transfers, then pause per draw
    always @(posedge clk) begin
        if (!rst_n) begin
            pix_valid <= 1'b0;
            src_wait = 0;
        end else if (!pix_valid || pix.ready) begin
            if (pix_valid) begin
                predicted_rgb.push_back(composite_pixel(pix_data));
            end
            if (src_wait != 0) begin
                src_wait--;
                pix_valid <= 1'b0;
            end else if (pixel_backlog.size() != 0) begin
                pix_data  <= pixel_backlog.pop_front();
                pix_valid <= 1'b1;
                src_wait = draw_gap(src_idle);
            end else begin
                pix_valid <= 1'b0;
            end
        end
    end

    // Receiver: compare each transfer with the oldest prediction
    always @(posedge clk) begin
        if (!rst_n) begin
            rgb_ready <= 1'b0;
            snk_wait = 0;
        end else begin
            if (rgb.valid && rgb_ready) begin
                if (predicted_rgb.size() == 0) begin
                    $error("result with no pending expectation");
                    mismatch_count++;
                end else begin
                    want = predicted_rgb.pop_front();
                    check_field("out_red", want.out_red, rgb.data.out_red);
                    check_field("out_green", want.out_green, rgb.data.out_green);
                    check_field("out_blue", want.out_blue, rgb.data.out_blue);
                    check_field("second_red", want.second_red, rgb.data.second_red);
                    check_field("second_green", want.second_green, rgb.data.second_green);
                    check_field("second_blue", want.second_blue, rgb.data.second_blue);
                end
                snk_wait = draw_gap(snk_idle);
            end
            if (out_hold) begin
                rgb_ready <= 1'b0;
            end else if (snk_wait != 0) begin
                snk_wait--;
                rgb_ready <= 1'b0;
            end else begin
                rgb_ready <= 1'b1;
            end
        end
    end

    // Long receiver stall so the pipeline fills and the input backs up
    initial begin
        wait (hold_go);
        @(posedge clk);
        out_hold <= 1'b1;
        repeat (200) @(posedge clk);
        out_hold <= 1'b0;
    end

    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic wait_drained();
        do begin
            @(negedge clk);
        end while (pixel_backlog.size() != 0 || pix_valid || predicted_rgb.size() != 0);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
        wait_drained();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(posedge clk);
        end while (!cfg.ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MODE:        reg_mode = val[1:0];
            CFG_FADE_WEIGHT: reg_weight = val[8:0];
            CFG_WIPE_COLUMN: reg_wipe = val;
            default:         ;
        endcase
        @(negedge clk);
    endtask

    task automatic random_burst(input int n, input int unsigned s_lvl,
                                input int unsigned r_lvl);
        src_idle = s_lvl;
        snk_idle = r_lvl;
        repeat (n) pixel_backlog.push_back(random_pixel());
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Plain mode straight out of reset: range ends and clamping
        src_idle = 1;
        snk_idle = 1;
        pixel_backlog.push_back(mk_pixel(0, 0, 0, 255, 255, 255, 0, 0, 0, 0));
        pixel_backlog.push_back(mk_pixel(255, 255, 255, 0, 0, 0, 255, 255, 255, 1023));
        pixel_backlog.push_back(mk_pixel(16, 128, 128, 235, 128, 128, 12, 34, 56, 512));
        pixel_backlog.push_back(mk_pixel(255, 128, 255, 0, 128, 0, 7, 8, 9, 300));
        pixel_backlog.push_back(mk_pixel(81, 90, 240, 145, 54, 34, 0, 0, 0, 1));

        // Key overlay: black keys through, wipe colour below the column
        write_reg(CFG_MODE, {8'd0, MODE_KEY_WIPE});
        write_reg(CFG_WIPE_COLUMN, 10'd5);
        pixel_backlog.push_back(mk_pixel(200, 60, 180, 50, 200, 100, 0, 0, 0, 0));
        pixel_backlog.push_back(mk_pixel(90, 30, 200, 60, 70, 80, 1, 0, 0, 4));
        pixel_backlog.push_back(mk_pixel(90, 30, 200, 60, 70, 80, 0, 0, 1, 5));
        pixel_backlog.push_back(mk_pixel(120, 128, 128, 16, 16, 16, 255, 255, 255, 1023));
        pixel_backlog.push_back(mk_pixel(40, 220, 10, 250, 5, 240, 0, 1, 0, 0));
        write_reg(CFG_WIPE_COLUMN, 10'd1023);
        pixel_backlog.push_back(mk_pixel(70, 70, 70, 70, 70, 70, 33, 44, 55, 1022));
        pixel_backlog.push_back(mk_pixel(70, 70, 70, 70, 70, 70, 33, 44, 55, 1023));
        write_reg(CFG_WIPE_COLUMN, 10'd0);
        pixel_backlog.push_back(mk_pixel(70, 70, 70, 70, 70, 70, 33, 44, 55, 0));

        // Crossfade at both weight ends, the middle and past the top
        write_reg(CFG_MODE, {8'd0, MODE_CROSSFADE});
        write_reg(CFG_FADE_WEIGHT, 10'd0);
        pixel_backlog.push_back(mk_pixel(235, 128, 128, 16, 128, 128, 1, 2, 3, 10));
        write_reg(CFG_FADE_WEIGHT, 10'd299);
        pixel_backlog.push_back(mk_pixel(235, 128, 128, 16, 128, 128, 1, 2, 3, 10));
        write_reg(CFG_FADE_WEIGHT, 10'd150);
        pixel_backlog.push_back(mk_pixel(255, 0, 255, 0, 255, 0, 0, 0, 0, 20));
        pixel_backlog.push_back(mk_pixel(180, 100, 160, 90, 200, 40, 9, 9, 9, 30));
        write_reg(CFG_FADE_WEIGHT, 10'd300);
        pixel_backlog.push_back(mk_pixel(200, 50, 150, 30, 220, 90, 5, 6, 7, 40));
        write_reg(CFG_FADE_WEIGHT, 10'd511);
        pixel_backlog.push_back(mk_pixel(200, 50, 150, 30, 220, 90, 5, 6, 7, 40));
        // bit 9 lies outside the weight register
        write_reg(CFG_FADE_WEIGHT, 10'h3FF);
        pixel_backlog.push_back(mk_pixel(10, 240, 30, 250, 20, 230, 5, 6, 7, 50));

        write_reg(CFG_MODE, {8'd0, MODE_SIDE});
        pixel_backlog.push_back(mk_pixel(100, 150, 200, 200, 150, 100, 0, 0, 0, 60));
        pixel_backlog.push_back(mk_pixel(0, 255, 0, 255, 0, 255, 255, 0, 255, 70));
        write_reg(CFG_SPARE, 10'h3FF);
        pixel_backlog.push_back(mk_pixel(128, 128, 128, 64, 64, 64, 1, 1, 1, 80));
        // upper data bits are dropped by the mode register
        write_reg(CFG_MODE, {8'hFF, MODE_PLAIN});
        pixel_backlog.push_back(mk_pixel(50, 100, 150, 150, 100, 50, 0, 0, 0, 90));

        // Random bursts across the register space
        write_reg(CFG_MODE, {8'($urandom), MODE_PLAIN});
        random_burst(65, 2, 0);

        write_reg(CFG_MODE, {8'($urandom), MODE_KEY_WIPE});
        write_reg(CFG_WIPE_COLUMN, 10'($urandom_range(0, 1023)));
        random_burst(65, 1, 1);

        write_reg(CFG_MODE, {8'($urandom), MODE_CROSSFADE});
        write_reg(CFG_FADE_WEIGHT, 10'($urandom_range(0, 299)));
        random_burst(90, 0, 1);
        hold_go = 1'b1;

        write_reg(CFG_MODE, {8'($urandom), MODE_SIDE});
        random_burst(65, 0, 2);

        write_reg(CFG_MODE, {8'($urandom), MODE_KEY_WIPE});
        write_reg(CFG_WIPE_COLUMN, 10'd1023);
        random_burst(65, 2, 2);

        write_reg(CFG_MODE, {8'($urandom), MODE_CROSSFADE});
        write_reg(CFG_FADE_WEIGHT, 10'd299);
        random_burst(50, 1, 0);

        write_reg(CFG_FADE_WEIGHT, {1'($urandom), 9'($urandom_range(300, 511))});
        random_burst(50, 0, 0);

        write_reg(CFG_MODE, {8'($urandom), MODE_KEY_WIPE});
        write_reg(CFG_WIPE_COLUMN, 10'd0);
        random_burst(50, 1, 2);

        write_reg(CFG_MODE, {8'($urandom), MODE_CROSSFADE});
        write_reg(CFG_FADE_WEIGHT, 10'd0);
        random_burst(40, 1, 1);

        wait_drained();
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
